// File: rtl/core/ll2uv_pkg.sv
package ll2uv_pkg;

    localparam int FOLD_LAT  = 8;
    localparam int SER_STEPS = 7;
    localparam int STEP_LAT  = 5;
    localparam int SER_LAT   = SER_STEPS * STEP_LAT;
    localparam int FIN_LAT   = 4;
    localparam int TOTAL_LAT = FOLD_LAT + SER_LAT + FIN_LAT;

    // angles in degrees scaled by 2^23
    localparam logic [30:0] DEG_45  = 31'd377487360;
    localparam logic [30:0] DEG_90  = 31'd754974720;
    localparam logic [30:0] DEG_180 = 31'd1509949440;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef struct packed {
        logic neg;
        logic cneg;
        logic swap;
    } fold_flags_t;

endpackage

// File: rtl/core/lonlat_to_unit_vector_core.sv
// Longitude/latitude (degrees, signed, 23 fractional bits) to a point on the
// unit sphere: x = cos(lat)cos(lon), y = cos(lat)sin(lon), z = sin(lat), each
// signed with OUT_FRAC_BITS fractional bits. Angles beyond +-180 / +-90 degrees
// are clamped. One word is taken every cycle while the output is not stalled;
// the pipe runs clamping, folding and radian conversion, then the seven Taylor
// steps of five stages each, then the final product and rounding. The whole
// pipe holds while the output word waits; tlast rides along with its point.
module lonlat_to_unit_vector_core
    import ll2uv_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lon_deg[31:0], lat_deg[62:32], zero pad
    input  logic        s_tlast,   // batch_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // x_out[31:0], y_out[63:32], z_out[95:64]
    output logic        m_tlast    // batch_end_out
);

    logic               en;
    logic               vld_reg  [TOTAL_LAT];
    logic               last_reg [TOTAL_LAT];
    logic signed [31:0] lon_a, lat_a;
    logic        [31:0] lon_x, lon_x2, lat_x, lat_x2;
    fold_flags_t        lon_ff, lat_ff;
    fold_flags_t        lon_fl_reg [SER_LAT];
    fold_flags_t        lat_fl_reg [SER_LAT];
    logic        [32:0] lon_s, lon_c, lat_s, lat_c;
    logic        [32:0] slon, clon, slat, clat;
    fold_flags_t        lon_fd, lat_fd;
    logic        [31:0] x_res, y_res, z_res;

    assign en       = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = en;
    assign lon_a    = $signed(s_tdata[31:0]);
    assign lat_a    = $signed({s_tdata[62], s_tdata[62:32]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TOTAL_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < TOTAL_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg[0]   <= s_tlast;
            lon_fl_reg[0] <= lon_ff;
            lat_fl_reg[0] <= lat_ff;
            for (int k = 1; k < TOTAL_LAT; k++) begin
                last_reg[k] <= last_reg[k-1];
            end
            for (int k = 1; k < SER_LAT; k++) begin
                lon_fl_reg[k] <= lon_fl_reg[k-1];
                lat_fl_reg[k] <= lat_fl_reg[k-1];
            end
        end
    end

    ll2uv_fold #(.LIMIT(DEG_180)) u_fold_lon (
        .aclk(aclk), .en(en), .angle(lon_a), .x(lon_x), .x2(lon_x2), .flags(lon_ff)
    );
    ll2uv_fold #(.LIMIT(DEG_90)) u_fold_lat (
        .aclk(aclk), .en(en), .angle(lat_a), .x(lat_x), .x2(lat_x2), .flags(lat_ff)
    );

    ll2uv_series #(.IS_COS(1'b0)) u_sin_lon (
        .aclk(aclk), .en(en), .x(lon_x), .x2(lon_x2), .y(lon_s)
    );
    ll2uv_series #(.IS_COS(1'b1)) u_cos_lon (
        .aclk(aclk), .en(en), .x(lon_x), .x2(lon_x2), .y(lon_c)
    );
    ll2uv_series #(.IS_COS(1'b0)) u_sin_lat (
        .aclk(aclk), .en(en), .x(lat_x), .x2(lat_x2), .y(lat_s)
    );
    ll2uv_series #(.IS_COS(1'b1)) u_cos_lat (
        .aclk(aclk), .en(en), .x(lat_x), .x2(lat_x2), .y(lat_c)
    );

    assign lon_fd = lon_fl_reg[SER_LAT-1];
    assign lat_fd = lat_fl_reg[SER_LAT-1];
    assign slon   = lon_fd.swap ? lon_c : lon_s;
    assign clon   = lon_fd.swap ? lon_s : lon_c;
    assign slat   = lat_fd.swap ? lat_c : lat_s;
    assign clat   = lat_fd.swap ? lat_s : lat_c;

    ll2uv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_x (
        .aclk(aclk), .en(en), .a(clat), .b(clon),
        .neg(lat_fd.cneg ^ lon_fd.cneg), .res(x_res)
    );
    ll2uv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_y (
        .aclk(aclk), .en(en), .a(clat), .b(slon),
        .neg(lat_fd.cneg ^ lon_fd.neg), .res(y_res)
    );
    ll2uv_finish #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fin_z (
        .aclk(aclk), .en(en), .a(slat), .b(ONE_Q32),
        .neg(lat_fd.neg), .res(z_res)
    );

    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_tlast  = last_reg[TOTAL_LAT-1];
    assign m_tdata  = {z_res, y_res, x_res};

    // full scale in the output format
    localparam longint FS = 64'sd1 <<< OUT_FRAC_BITS;

    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (OUT_FRAC_BITS > 30 ||
            (longint'($signed(m_tdata[31:0])) <= FS &&
             longint'($signed(m_tdata[31:0])) >= -FS)))
        else $error("x component beyond full scale");

    a_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (OUT_FRAC_BITS > 30 ||
            (longint'($signed(m_tdata[63:32])) <= FS &&
             longint'($signed(m_tdata[63:32])) >= -FS)))
        else $error("y component beyond full scale");

    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (OUT_FRAC_BITS > 30 ||
            (longint'($signed(m_tdata[95:64])) <= FS &&
             longint'($signed(m_tdata[95:64])) >= -FS)))
        else $error("z component beyond full scale");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(vld_reg[0])))
        else $error("pipe advanced during output stall");

endmodule

// File: rtl/core/ll2uv_fold.sv
module ll2uv_fold
    import ll2uv_pkg::*;
#(
    parameter logic [30:0] LIMIT = 31'd1509949440
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output logic        [31:0] x,
    output logic        [31:0] x2,
    output fold_flags_t        flags
);

    localparam logic signed [31:0] LIM_P    = $signed({1'b0, LIMIT});
    localparam logic [34:0]        PI_Q33   = 35'h6487ED511;
    localparam logic [17:0]        P_LO     = PI_Q33[17:0];
    localparam logic [16:0]        P_HI     = PI_Q33[34:18];
    localparam logic [64:0]        RAD_HALF = 65'(45) << 25;
    localparam logic [63:0]        M45_W    = (64'd1 << 38) / 64'd45;
    localparam logic [32:0]        M45      = M45_W[32:0];

    logic signed [31:0] a_c;
    logic        [30:0] s1_u_reg, s1_u_next;
    logic               s1_neg_reg, s1_neg_next;
    logic        [30:0] u_f;
    logic        [28:0] s2_u_reg, s2_u_next;
    fold_flags_t        fl_next;
    fold_flags_t        fl_reg [FOLD_LAT-1];
    logic        [46:0] s3_pl_reg, s3_pl_next;
    logic        [45:0] s3_ph_reg, s3_ph_next;
    logic        [64:0] s4_sum;
    logic        [37:0] s4_w_reg, s4_w_next;
    logic        [51:0] s5_ql_reg, s5_ql_next;
    logic        [51:0] s5_qh_reg, s5_qh_next;
    logic        [37:0] s5_w_reg;
    logic        [71:0] s6_t;
    logic        [32:0] s6_q0_reg, s6_q0_next;
    logic        [37:0] s6_w_reg;
    logic        [38:0] s7_r;
    logic        [31:0] s7_x_reg, s7_x_next;
    logic        [64:0] s8_sq;
    logic        [31:0] s8_x_reg;
    logic        [31:0] s8_x2_reg, s8_x2_next;

    always_comb begin
        if (angle > LIM_P) begin
            a_c = LIM_P;
        end else if (angle < -LIM_P) begin
            a_c = -LIM_P;
        end else begin
            a_c = angle;
        end
        s1_neg_next = a_c[31];
        s1_u_next   = a_c[31] ? 31'(-a_c) : a_c[30:0];
    end

    always_comb begin
        fl_next.neg = s1_neg_reg;
        if (s1_u_reg > DEG_90) begin
            u_f          = DEG_180 - s1_u_reg;
            fl_next.cneg = 1'b1;
        end else begin
            u_f          = s1_u_reg;
            fl_next.cneg = 1'b0;
        end
        fl_next.swap = u_f > DEG_45;
        s2_u_next    = 29'(fl_next.swap ? DEG_90 - u_f : u_f);
    end

    always_comb begin
        s3_pl_next = 47'(s2_u_reg) * 47'(P_LO);
        s3_ph_next = 46'(s2_u_reg) * 46'(P_HI);
        s4_sum     = (65'(s3_ph_reg) << 18) + 65'(s3_pl_reg) + RAD_HALF;
        s4_w_next  = s4_sum[63:26];
        s5_ql_next = 52'(s4_w_reg[18:0]) * 52'(M45);
        s5_qh_next = 52'(s4_w_reg[37:19]) * 52'(M45);
        s6_t       = (72'(s5_qh_reg) << 19) + 72'(s5_ql_reg);
        s6_q0_next = s6_t[70:38];
        s7_r       = 39'(s6_w_reg) - 39'(s6_q0_reg) * 39'(45);
        s7_x_next  = 32'(s6_q0_reg + 33'(s7_r >= 39'(45)));
        s8_sq      = 65'(64'(s7_x_reg) * 64'(s7_x_reg)) + (65'(1) << 31);
        s8_x2_next = s8_sq[63:32];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_u_reg   <= s1_u_next;
            s1_neg_reg <= s1_neg_next;
            s2_u_reg   <= s2_u_next;
            fl_reg[0]  <= fl_next;
            for (int k = 1; k < FOLD_LAT - 1; k++) begin
                fl_reg[k] <= fl_reg[k-1];
            end
            s3_pl_reg  <= s3_pl_next;
            s3_ph_reg  <= s3_ph_next;
            s4_w_reg   <= s4_w_next;
            s5_ql_reg  <= s5_ql_next;
            s5_qh_reg  <= s5_qh_next;
            s5_w_reg   <= s4_w_reg;
            s6_q0_reg  <= s6_q0_next;
            s6_w_reg   <= s5_w_reg;
            s7_x_reg   <= s7_x_next;
            s8_x_reg   <= s7_x_reg;
            s8_x2_reg  <= s8_x2_next;
        end
    end

    assign x     = s8_x_reg;
    assign x2    = s8_x2_reg;
    assign flags = fl_reg[FOLD_LAT-2];

endmodule

// File: rtl/core/ll2uv_series.sv
module ll2uv_series
    import ll2uv_pkg::*;
#(
    parameter bit IS_COS = 1'b0
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] x,
    input  logic [31:0] x2,
    output logic [32:0] y
);

    localparam int X2_LEN = STEP_LAT * (SER_STEPS - 1);

    function automatic int step_div(int i, bit cos_sel);
        int k;
        k = cos_sel ? 2 * i + 1 : 2 * i + 2;
        return k * (k + 1);
    endfunction

    logic        [32:0] term_in [SER_STEPS];
    logic signed [34:0] sum_in  [SER_STEPS+1];
    logic        [31:0] x2_line_reg [X2_LEN];
    logic signed [34:0] sum_fin;

    assign term_in[0] = IS_COS ? ONE_Q32 : {1'b0, x};
    assign sum_in[0]  = $signed({2'b00, term_in[0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_line_reg[0] <= x2;
            for (int k = 1; k < X2_LEN; k++) begin
                x2_line_reg[k] <= x2_line_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < SER_STEPS; i++) begin : g_step
        localparam int          D   = step_div(i, IS_COS);
        localparam logic [63:0] M_W = (64'd1 << 35) / 64'(D);
        localparam logic [34:0] M   = M_W[34:0];

        logic        [31:0] x2s;
        logic        [48:0] a_pl_reg, a_pl_next;
        logic        [47:0] a_ph_reg, a_ph_next;
        logic signed [34:0] a_sum_reg;
        logic        [65:0] b_t;
        logic        [32:0] b_v_reg, b_v_next;
        logic signed [34:0] b_sum_reg;
        logic        [51:0] c_pl_reg, c_pl_next;
        logic        [50:0] c_ph_reg, c_ph_next;
        logic        [32:0] c_v_reg;
        logic signed [34:0] c_sum_reg;
        logic        [68:0] d_t;
        logic        [32:0] d_q0_reg, d_q0_next;
        logic        [32:0] d_v_reg;
        logic signed [34:0] d_sum_reg;
        logic        [33:0] e_r;
        logic        [32:0] e_term_reg, e_term_next;
        logic signed [34:0] e_sum_reg, e_sum_next;

        if (i == 0) begin : g_x2_first
            assign x2s = x2;
        end else begin : g_x2_line
            assign x2s = x2_line_reg[STEP_LAT*i-1];
        end

        always_comb begin
            a_pl_next   = 49'(term_in[i][16:0]) * 49'(x2s);
            a_ph_next   = 48'(term_in[i][32:17]) * 48'(x2s);
            b_t         = (66'(a_ph_reg) << 17) + 66'(a_pl_reg) + (66'(1) << 31);
            b_v_next    = 33'(b_t[63:32]) + 33'(D / 2);
            c_pl_next   = 52'(b_v_reg[16:0]) * 52'(M);
            c_ph_next   = 51'(b_v_reg[32:17]) * 51'(M);
            d_t         = (69'(c_ph_reg) << 17) + 69'(c_pl_reg);
            d_q0_next   = d_t[67:35];
            e_r         = 34'(d_v_reg) - 34'(d_q0_reg) * 34'(D);
            e_term_next = d_q0_reg + 33'(e_r >= 34'(D));
            if (i % 2 == 0) begin
                e_sum_next = d_sum_reg - $signed({2'b00, e_term_next});
            end else begin
                e_sum_next = d_sum_reg + $signed({2'b00, e_term_next});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_pl_reg   <= a_pl_next;
                a_ph_reg   <= a_ph_next;
                a_sum_reg  <= sum_in[i];
                b_v_reg    <= b_v_next;
                b_sum_reg  <= a_sum_reg;
                c_pl_reg   <= c_pl_next;
                c_ph_reg   <= c_ph_next;
                c_v_reg    <= b_v_reg;
                c_sum_reg  <= b_sum_reg;
                d_q0_reg   <= d_q0_next;
                d_v_reg    <= c_v_reg;
                d_sum_reg  <= c_sum_reg;
                e_term_reg <= e_term_next;
                e_sum_reg  <= e_sum_next;
            end
        end

        assign sum_in[i+1] = e_sum_reg;

        if (i < SER_STEPS - 1) begin : g_next
            assign term_in[i+1] = e_term_reg;
        end
    end

    assign sum_fin = sum_in[SER_STEPS];

    always_comb begin
        if (sum_fin < 0) begin
            y = '0;
        end else if (sum_fin > $signed({2'b00, ONE_Q32})) begin
            y = ONE_Q32;
        end else begin
            y = sum_fin[32:0];
        end
    end

endmodule

// File: rtl/core/ll2uv_finish.sv
module ll2uv_finish
    import ll2uv_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] a,
    input  logic [32:0] b,
    input  logic        neg,
    output logic [31:0] res
);

    localparam int          SH      = 63 - OUT_FRAC_BITS;
    localparam logic [64:0] RND     = 65'(1) << (SH - 1);
    localparam logic [64:0] MAX_NEG = 65'(1) << 31;
    localparam logic [64:0] MAX_POS = MAX_NEG - 65'(1);

    logic [49:0] f1_pl_reg, f1_pl_next;
    logic [48:0] f1_ph_reg, f1_ph_next;
    logic        f1_neg_reg, f2_neg_reg, f3_neg_reg;
    logic [65:0] f2_t;
    logic [63:0] f2_p_reg, f2_p_next;
    logic [64:0] f3_m_reg, f3_m_next;
    logic [64:0] f4_mm;
    logic [31:0] f4_res_reg, f4_res_next;

    always_comb begin
        f1_pl_next = 50'(a[16:0]) * 50'(b);
        f1_ph_next = 49'(a[32:17]) * 49'(b);
        f2_t       = (66'(f1_ph_reg) << 17) + 66'(f1_pl_reg);
        f2_p_next  = f2_t[64:1];
        f3_m_next  = (65'(f2_p_reg) + RND) >> SH;
        if (f3_m_reg == '0) begin
            f4_mm       = '0;
            f4_res_next = '0;
        end else if (f3_neg_reg) begin
            f4_mm       = (f3_m_reg > MAX_NEG) ? MAX_NEG : f3_m_reg;
            f4_res_next = 32'(-f4_mm);
        end else begin
            f4_mm       = (f3_m_reg > MAX_POS) ? MAX_POS : f3_m_reg;
            f4_res_next = f4_mm[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_pl_reg  <= f1_pl_next;
            f1_ph_reg  <= f1_ph_next;
            f1_neg_reg <= neg;
            f2_p_reg   <= f2_p_next;
            f2_neg_reg <= f1_neg_reg;
            f3_m_reg   <= f3_m_next;
            f3_neg_reg <= f2_neg_reg;
            f4_res_reg <= f4_res_next;
        end
    end

    assign res = f4_res_reg;

endmodule
